FILE: rtl/core/spcm_pkg.sv
// Shared types, codes and constants of the stall and proximity collision monitor.
package spcm_pkg;

  // Configuration port geometry: four 32-bit registers at byte addresses 0, 4, 8 and 12.
  localparam int CFG_ADDR_W = 4;
  localparam int CFG_DATA_W = 32;

  // Register indexes, taken from paddr[3:2].
  localparam logic [1:0] REG_POS_TOL   = 2'd0;
  localparam logic [1:0] REG_HEAD_TOL  = 2'd1;
  localparam logic [1:0] REG_STALL_TKS = 2'd2;
  localparam logic [1:0] REG_RANGE_LIM = 2'd3;

  // Register reset values.
  localparam logic [19:0] POS_TOL_RST   = 20'd3277;
  localparam logic [18:0] HEAD_TOL_RST  = 19'd3277;
  localparam logic [9:0]  STALL_TKS_RST = 10'd10;
  localparam logic [22:0] RANGE_LIM_RST = 23'd229376;

  // Fixed thresholds with 16 fraction bits: Q16.16 for the 32-bit ones.
  localparam logic signed [31:0] NEAR_ORIGIN_MAX = 32'sd655;     // 0.01
  localparam logic signed [31:0] VEL_DEADBAND    = 32'sd65;      // 0.001
  localparam logic signed [23:0] DRIVE_LIMIT     = 24'sd655360;  // 10.0
  localparam logic [22:0]        OBSTACLE_MAX    = 23'd9175;     // 0.14 m

  // Lidar sectors, first beam inclusive and last beam exclusive.
  localparam logic [8:0] FWD_SECTOR_LO = 9'd236;
  localparam logic [8:0] FWD_SECTOR_HI = 9'd304;
  localparam logic [8:0] REV_SECTOR_LO = 9'd56;
  localparam logic [8:0] REV_SECTOR_HI = 9'd124;

  localparam logic [11:0] STALL_STEP_UP = 12'd3;

  typedef enum logic [2:0] {
    OP_POSE  = 3'd0,
    OP_VEL   = 3'd1,
    OP_RPWM  = 3'd2,
    OP_LPWM  = 3'd3,
    OP_RANGE = 3'd4,
    OP_START = 3'd5,
    OP_TICK  = 3'd6
  } op_t;

  typedef enum logic [1:0] {
    DIR_IDLE = 2'd0,
    DIR_FWD  = 2'd1,
    DIR_REV  = 2'd2
  } dir_t;

  typedef struct packed {
    logic [19:0] position_tolerance;
    logic [18:0] heading_tolerance;
    logic [9:0]  stall_ticks;
    logic [22:0] range_limit;
  } cfg_t;

  typedef struct packed {
    op_t                operation;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] heading;
    logic signed [31:0] velocity;
    logic signed [23:0] pwm_value;
    logic [8:0]         range_index;
    logic [22:0]        range_value;
    logic               range_is_inf;
    logic               start_enable;
  } item_t;

  typedef struct packed {
    logic valid;
    logic stall_alert;
    logic obstacle_alert;
  } result_t;

endpackage

FILE: rtl/core/spcm_in_if.sv
// Input event channel: valid/ready handshake with the event word.
interface spcm_in_if;
  logic               valid;
  logic               ready;
  logic [2:0]         operation;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [31:0] heading;
  logic signed [31:0] velocity;
  logic signed [23:0] pwm_value;
  logic [8:0]         range_index;
  logic [22:0]        range_value;
  logic               range_is_inf;
  logic               start_enable;

  modport source (
    output valid, operation, pos_x, pos_y, heading, velocity, pwm_value,
           range_index, range_value, range_is_inf, start_enable,
    input  ready
  );

  modport sink (
    input  valid, operation, pos_x, pos_y, heading, velocity, pwm_value,
           range_index, range_value, range_is_inf, start_enable,
    output ready
  );
endinterface

FILE: rtl/core/spcm_out_if.sv
// Alert result channel: valid/ready handshake with the alert word.
interface spcm_out_if;
  logic valid;
  logic ready;
  logic stall_alert;
  logic obstacle_alert;

  modport source (
    output valid, stall_alert, obstacle_alert,
    input  ready
  );

  modport sink (
    input  valid, stall_alert, obstacle_alert,
    output ready
  );
endinterface

FILE: rtl/core/stall_and_proximity_collision_monitor_core.sv
// Top level of the stall and proximity collision monitor.
// Flow: an accepted input word is registered in the input stage and worked out by the engine
// once the result register is free; its alert word, if any, is then held in the result register.
// Throughput: one input word per cycle; only a result register that is full and not taken
// holds the input stage back.
// Reset: synchronous and active low; clears valids and state, loads register defaults.
module stall_and_proximity_collision_monitor_core
  import spcm_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  spcm_in_if.sink               in_ch,
  spcm_out_if.source            out_ch,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);

  cfg_t    cfg;
  result_t res;

  // Input stage: one word held for the engine.
  item_t s1_item_r, s1_item_nxt;
  logic  s1_valid_r, s1_valid_nxt;

  // Result register: separates the engine from a stalled consumer.
  logic  out_valid_r, out_valid_nxt;
  logic  out_stall_r, out_stall_nxt;
  logic  out_obst_r, out_obst_nxt;

  logic  adv;
  logic  in_take;
  logic  out_free;

  spcm_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // The word in the input stage is worked out whenever the result register can take
  // whatever it produces. Words that produce no alert still wait here, which keeps the
  // order of state updates and results identical to the order of arrival.
  assign out_free = !out_valid_r || out_ch.ready;
  assign adv      = s1_valid_r && out_free;
  assign in_take  = in_ch.valid && in_ch.ready;

  assign in_ch.ready = !s1_valid_r || adv;

  spcm_engine u_engine (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (adv),
    .item  (s1_item_r),
    .cfg   (cfg),
    .res   (res)
  );

  always_comb begin
    s1_item_nxt  = s1_item_r;
    s1_valid_nxt = s1_valid_r;
    if (in_take) begin
      s1_item_nxt.operation    = op_t'(in_ch.operation);
      s1_item_nxt.pos_x        = in_ch.pos_x;
      s1_item_nxt.pos_y        = in_ch.pos_y;
      s1_item_nxt.heading      = in_ch.heading;
      s1_item_nxt.velocity     = in_ch.velocity;
      s1_item_nxt.pwm_value    = in_ch.pwm_value;
      s1_item_nxt.range_index  = in_ch.range_index;
      s1_item_nxt.range_value  = in_ch.range_value;
      s1_item_nxt.range_is_inf = in_ch.range_is_inf;
      s1_item_nxt.start_enable = in_ch.start_enable;
      s1_valid_nxt             = 1'b1;
    end else if (adv) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_stall_nxt = out_stall_r;
    out_obst_nxt  = out_obst_r;
    if (adv && res.valid) begin
      out_valid_nxt = 1'b1;
      out_stall_nxt = res.stall_alert;
      out_obst_nxt  = res.obstacle_alert;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s1_item_r   <= s1_item_nxt;
    out_stall_r <= out_stall_nxt;
    out_obst_r  <= out_obst_nxt;
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.stall_alert    = out_stall_r;
  assign out_ch.obstacle_alert = out_obst_r;

  // A result waiting on a stalled consumer must never be overwritten by the engine.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ch.ready) |-> !adv)
    else $error("engine advanced over a pending alert word");

  // Input is refused only while the input stage holds a word.
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> s1_valid_r)
    else $error("input refused with an empty input stage");

  // A new alert word only ever comes from a tick event.
  a_result_from_tick: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(s1_item_r.operation == OP_TICK))
    else $error("alert word produced by an event other than a tick");

  // An emptied input stage means the engine took its word.
  a_stage_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !in_take && !adv) |=> s1_valid_r)
    else $error("input stage lost a word");

endmodule

FILE: rtl/core/spcm_cfg.sv
// APB-style configuration register bank of the monitor.
module spcm_cfg
  import spcm_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready,
  output cfg_t                  cfg
);

  cfg_t       cfg_r;
  cfg_t       cfg_nxt;
  logic [1:0] reg_idx;
  logic       wr_en;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign wr_en   = psel && penable && pwrite;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (reg_idx)
        REG_POS_TOL:   cfg_nxt.position_tolerance = pwdata[19:0];
        REG_HEAD_TOL:  cfg_nxt.heading_tolerance  = pwdata[18:0];
        REG_STALL_TKS: cfg_nxt.stall_ticks        = pwdata[9:0];
        REG_RANGE_LIM: cfg_nxt.range_limit        = pwdata[22:0];
        default:       cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.position_tolerance <= POS_TOL_RST;
      cfg_r.heading_tolerance  <= HEAD_TOL_RST;
      cfg_r.stall_ticks        <= STALL_TKS_RST;
      cfg_r.range_limit        <= RANGE_LIM_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_POS_TOL:   prdata = {12'd0, cfg_r.position_tolerance};
      REG_HEAD_TOL:  prdata = {13'd0, cfg_r.heading_tolerance};
      REG_STALL_TKS: prdata = {22'd0, cfg_r.stall_ticks};
      REG_RANGE_LIM: prdata = {9'd0, cfg_r.range_limit};
      default:       prdata = '0;
    endcase
  end

  assign cfg = cfg_r;

endmodule

FILE: rtl/core/spcm_engine.sv
// Event engine: holds the monitor state, works out each event combinationally and registers the new state.
module spcm_engine
  import spcm_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    en,
  input  item_t   item,
  input  cfg_t    cfg,
  output result_t res
);

  logic signed [31:0] last_x_r, last_x_nxt;
  logic signed [31:0] last_y_r, last_y_nxt;
  logic signed [31:0] last_head_r, last_head_nxt;
  logic               armed_r, armed_nxt;
  logic               still_r, still_nxt;
  logic               obst_r, obst_nxt;
  dir_t               dir_r, dir_nxt;
  logic               rdrive_r, rdrive_nxt;
  logic               ldrive_r, ldrive_nxt;
  logic               check_en_r, check_en_nxt;
  logic [11:0]        cnt_r, cnt_nxt;

  // Pose comparison: differences are taken at 33 bits so that they are exact.
  logic signed [32:0] dx, dy, dh;
  logic [32:0]        adx, ady, adh;
  logic               quiet;
  logic               near_origin;

  logic [22:0] reading;
  logic        in_sector;
  logic        drive_high;

  logic [12:0] cnt_sum;
  logic [11:0] cnt_up;
  logic [11:0] cnt_upd;
  logic [11:0] stall_lim;
  logic        stall_hit;

  assign dx  = {item.pos_x[31], item.pos_x} - {last_x_r[31], last_x_r};
  assign dy  = {item.pos_y[31], item.pos_y} - {last_y_r[31], last_y_r};
  assign dh  = {item.heading[31], item.heading} - {last_head_r[31], last_head_r};
  assign adx = dx[32] ? 33'(-dx) : 33'(dx);
  assign ady = dy[32] ? 33'(-dy) : 33'(dy);
  assign adh = dh[32] ? 33'(-dh) : 33'(dh);

  assign quiet = (adx < {13'd0, cfg.position_tolerance}) &&
                 (ady < {13'd0, cfg.position_tolerance}) &&
                 (adh < {14'd0, cfg.heading_tolerance});

  assign near_origin = (last_x_r <= NEAR_ORIGIN_MAX) && (last_x_r >= -NEAR_ORIGIN_MAX) &&
                       (last_y_r <= NEAR_ORIGIN_MAX) && (last_y_r >= -NEAR_ORIGIN_MAX) &&
                       (last_head_r <= NEAR_ORIGIN_MAX) &&
                       (last_head_r >= -NEAR_ORIGIN_MAX);

  assign drive_high = (item.pwm_value > DRIVE_LIMIT) || (item.pwm_value < -DRIVE_LIMIT);

  assign reading = item.range_is_inf ? cfg.range_limit : item.range_value;

  always_comb begin
    unique case (dir_r)
      DIR_FWD: in_sector = (item.range_index >= FWD_SECTOR_LO) &&
                           (item.range_index < FWD_SECTOR_HI);
      DIR_REV: in_sector = (item.range_index >= REV_SECTOR_LO) &&
                           (item.range_index < REV_SECTOR_HI);
      default: in_sector = 1'b0;
    endcase
  end

  // Leaky stall counter: up by three with saturation, otherwise down by one to zero.
  assign cnt_sum   = {1'b0, cnt_r} + {1'b0, STALL_STEP_UP};
  assign cnt_up    = cnt_sum[12] ? 12'hFFF : cnt_sum[11:0];
  assign cnt_upd   = (still_r && (rdrive_r || ldrive_r)) ? cnt_up :
                     (cnt_r != 12'd0) ? (cnt_r - 12'd1) : cnt_r;
  assign stall_lim = {1'b0, cfg.stall_ticks, 1'b0} + {2'b00, cfg.stall_ticks};
  assign stall_hit = cnt_upd >= stall_lim;

  always_comb begin
    last_x_nxt    = last_x_r;
    last_y_nxt    = last_y_r;
    last_head_nxt = last_head_r;
    armed_nxt     = armed_r;
    still_nxt     = still_r;
    obst_nxt      = obst_r;
    dir_nxt       = dir_r;
    rdrive_nxt    = rdrive_r;
    ldrive_nxt    = ldrive_r;
    check_en_nxt  = check_en_r;
    cnt_nxt       = cnt_r;
    res           = '0;
    if (en) begin
      unique case (item.operation)
        OP_POSE: begin
          if (!near_origin && !armed_r && quiet) begin
            armed_nxt = 1'b1;
          end else begin
            if (!near_origin) begin
              still_nxt = quiet;
            end
            last_x_nxt    = item.pos_x;
            last_y_nxt    = item.pos_y;
            last_head_nxt = item.heading;
          end
        end
        OP_VEL: begin
          if (item.velocity > VEL_DEADBAND) begin
            dir_nxt = DIR_FWD;
          end else if (item.velocity < -VEL_DEADBAND) begin
            dir_nxt = DIR_REV;
          end else begin
            dir_nxt = DIR_IDLE;
          end
        end
        OP_RPWM:  rdrive_nxt = drive_high;
        OP_LPWM:  ldrive_nxt = drive_high;
        OP_RANGE: begin
          if (in_sector && (reading <= OBSTACLE_MAX)) begin
            obst_nxt = 1'b1;
          end
        end
        OP_START: check_en_nxt = item.start_enable;
        OP_TICK: begin
          if (check_en_r) begin
            cnt_nxt                = stall_hit ? 12'd0 : cnt_upd;
            obst_nxt               = 1'b0;
            res.valid              = 1'b1;
            res.stall_alert        = stall_hit;
            res.obstacle_alert     = obst_r;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_x_r    <= '0;
      last_y_r    <= '0;
      last_head_r <= '0;
      armed_r     <= 1'b0;
      still_r     <= 1'b0;
      obst_r      <= 1'b0;
      dir_r       <= DIR_IDLE;
      rdrive_r    <= 1'b0;
      ldrive_r    <= 1'b0;
      check_en_r  <= 1'b0;
      cnt_r       <= '0;
    end else begin
      last_x_r    <= last_x_nxt;
      last_y_r    <= last_y_nxt;
      last_head_r <= last_head_nxt;
      armed_r     <= armed_nxt;
      still_r     <= still_nxt;
      obst_r      <= obst_nxt;
      dir_r       <= dir_nxt;
      rdrive_r    <= rdrive_nxt;
      ldrive_r    <= ldrive_nxt;
      check_en_r  <= check_en_nxt;
      cnt_r       <= cnt_nxt;
    end
  end

endmodule
